### rtl/core/bcdc_pkg.sv
// ----------------------------------------------------------------------------
// bcdc_pkg
// Shared types, codes and helper functions for the BCD time-of-day clock.
// ----------------------------------------------------------------------------
package bcdc_pkg;

  // Event kinds carried on the input tuser
  localparam logic [1:0] ACT_TIMER  = 2'd0;
  localparam logic [1:0] ACT_SWITCH = 2'd1;
  localparam logic [1:0] ACT_BUTTON = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_TICKS_PER_SEC = 3'd0;
  localparam logic [2:0] CFG_SECS_PER_SET  = 3'd1;
  localparam logic [2:0] CFG_SEL_SWITCH    = 3'd2;
  localparam logic [2:0] CFG_BUTTON_EN     = 3'd3;

  // Reset values
  localparam logic [15:0] MINSEC_RESET = 16'h5957;
  localparam logic [3:0]  TPS_RESET    = 4'd10;
  localparam logic [3:0]  SPS_RESET    = 4'd3;
  localparam logic [3:0]  SEL_RESET    = 4'd1;

  localparam logic [4:0] HOUR_LAST = 5'd23;
  localparam logic [7:0] SEG_BLANK = 8'hFF;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } seq_state_t;

  // Clock time as held by the block
  typedef struct packed {
    logic [4:0]  hour;
    logic [15:0] minsec;
  } clk_time_t;

  // Wrap limit of each mm:ss digit, lowest first
  function automatic logic [4:0] digit_limit(input logic [1:0] idx);
    logic [4:0] lim;
    begin
      case (idx)
        2'd0:    lim = 5'd10;
        2'd1:    lim = 5'd6;
        2'd2:    lim = 5'd10;
        default: lim = 5'd6;
      endcase
      return lim;
    end
  endfunction

  // Active-low seven-segment pattern; digits above nine blank
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    begin
      case (d)
        4'd0:    s = 8'b11000000;
        4'd1:    s = 8'b11111001;
        4'd2:    s = 8'hA4;
        4'd3:    s = 8'hB0;
        4'd4:    s = 8'h99;
        4'd5:    s = 8'h92;
        4'd6:    s = 8'h82;
        4'd7:    s = 8'hF8;
        4'd8:    s = 8'h80;
        4'd9:    s = 8'b10010000;
        default: s = SEG_BLANK;
      endcase
      return s;
    end
  endfunction

endpackage

### rtl/core/bcd_clock_with_set_events.sv
// ----------------------------------------------------------------------------
// bcd_clock_with_set_events
// Time-of-day clock in BCD mm:ss plus binary hours, advanced by timer ticks
// and by switch or button set events, with seven-segment outputs.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_tvalid/in_tready | tuser: action; tdata: pending, edges
//  out     | out_tvalid/tready   | tdata: six segment patterns, time, hour
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  An item is stepped n times between acceptance and its result, n being the
//  seconds it adds (0 or 1 for a timer tick, up to 15 for a set event): the
//  single one-second step unit is applied once per cycle.
//  Reset gives 00:59:57 with the prescaler at zero and default registers.
//  A stalled result stays in the output register; the next item is taken
//  meanwhile, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module bcd_clock_with_set_events
  import bcdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] timer_pending, [10:1] edges, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] seg_sec_ones, [15:8] seg_sec_tens,
                                  // [23:16] seg_min_ones, [31:24] seg_min_tens,
                                  // [39:32] seg_hour_ones, [47:40] seg_hour_tens,
                                  // [63:48] time_bcd, [68:64] hour_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  seq_state_t  state_r, state_nxt;
  clk_time_t   time_r, time_nxt, step_time;
  logic [3:0]  sub_r, sub_nxt;
  logic [3:0]  remain_r, remain_nxt;
  logic [3:0]  tps_r, sps_r, sel_r;
  logic        btn_en_r;
  logic        out_valid_r, out_valid_nxt;
  logic [71:0] out_data_r;
  logic [47:0] segs;
  logic        in_acc, out_load;
  logic        pending;
  logic [9:0]  edges;
  logic [15:0] edge_ext;
  logic [3:0]  sub_inc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign pending   = in_tdata[0];
  assign edges     = in_tdata[10:1];
  assign edge_ext  = {6'd0, edges};
  assign sub_inc   = sub_r + 4'd1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r    <= TPS_RESET;
      sps_r    <= SPS_RESET;
      sel_r    <= SEL_RESET;
      btn_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TICKS_PER_SEC: tps_r    <= cfg_data;
        CFG_SECS_PER_SET:  sps_r    <= cfg_data;
        CFG_SEL_SWITCH:    sel_r    <= cfg_data;
        CFG_BUTTON_EN:     btn_en_r <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  bcdc_sec_unit u_sec (
    .cur (time_r),
    .nxt (step_time)
  );

  bcdc_seg_enc u_seg (
    .cur  (time_r),
    .segs (segs)
  );

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Sequencer: decode the event, apply the step unit, then hand off the result
  always_comb begin
    state_nxt     = state_r;
    sub_nxt       = sub_r;
    remain_nxt    = remain_r;
    time_nxt      = time_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          remain_nxt = '0;
          case (in_tuser)
            ACT_TIMER: begin
              if (pending) begin
                if (sub_inc == tps_r) begin
                  sub_nxt    = '0;
                  remain_nxt = 4'd1;
                end else begin
                  sub_nxt = sub_inc;
                end
              end
            end
            ACT_SWITCH: begin
              if (edge_ext[sel_r]) remain_nxt = sps_r;
            end
            ACT_BUTTON: begin
              if (btn_en_r && edges[0]) remain_nxt = sps_r;
            end
            default: ;
          endcase
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (remain_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          time_nxt   = step_time;
          remain_nxt = remain_r - 4'd1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sub_r       <= '0;
      remain_r    <= '0;
      time_r      <= '{hour: 5'd0, minsec: MINSEC_RESET};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sub_r       <= sub_nxt;
      remain_r    <= remain_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {3'd0, time_r.hour, time_r.minsec, segs};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("ready while busy");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && remain_r == '0) |=> (state_r == ST_DONE))
    else $error("step loop did not finish");

  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    time_r.hour <= HOUR_LAST) else $error("hour out of range");

  a_sub_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(sub_r)) else $error("prescaler moved without an item");

endmodule

### rtl/core/bcdc_sec_unit.sv
// ----------------------------------------------------------------------------
// bcdc_sec_unit
// Shared one-second step: BCD mm:ss increment with carry into the hours.
// ----------------------------------------------------------------------------
module bcdc_sec_unit
  import bcdc_pkg::*;
(
  input  clk_time_t cur,
  output clk_time_t nxt
);

  logic [15:0] ms;
  logic        carry;
  logic [4:0]  sum;

  // Ripple the carry through the four digits
  always_comb begin
    ms    = cur.minsec;
    carry = 1'b1;
    sum   = '0;
    for (int i = 0; i < 4; i++) begin
      sum = {1'b0, cur.minsec[4*i +: 4]} + 5'd1;
      if (carry) begin
        if (sum >= digit_limit(2'(i))) begin
          ms[4*i +: 4] = 4'd0;
        end else begin
          ms[4*i +: 4] = sum[3:0];
          carry        = 1'b0;
        end
      end
    end
  end

  // Carry out of 59:59 advances the hour modulo 24
  always_comb begin
    nxt.minsec = ms;
    if (!carry) begin
      nxt.hour = cur.hour;
    end else if (cur.hour >= HOUR_LAST) begin
      nxt.hour = '0;
    end else begin
      nxt.hour = cur.hour + 5'd1;
    end
  end

endmodule

### rtl/core/bcdc_seg_enc.sv
// ----------------------------------------------------------------------------
// bcdc_seg_enc
// Display encoder: six active-low digit patterns from the clock time.
// ----------------------------------------------------------------------------
module bcdc_seg_enc
  import bcdc_pkg::*;
(
  input  clk_time_t   cur,
  output logic [47:0] segs   // sec ones, sec tens, min ones, min tens, hr ones, hr tens
);

  logic [3:0] hr_tens;
  logic [3:0] hr_ones;

  // Split the binary hour into decimal digits
  always_comb begin
    if (cur.hour >= 5'd30) begin
      hr_tens = 4'd3;
      hr_ones = 4'(cur.hour - 5'd30);
    end else if (cur.hour >= 5'd20) begin
      hr_tens = 4'd2;
      hr_ones = 4'(cur.hour - 5'd20);
    end else if (cur.hour >= 5'd10) begin
      hr_tens = 4'd1;
      hr_ones = 4'(cur.hour - 5'd10);
    end else begin
      hr_tens = 4'd0;
      hr_ones = cur.hour[3:0];
    end
  end

  assign segs = {seg_of(hr_tens), seg_of(hr_ones),
                 seg_of(cur.minsec[15:12]), seg_of(cur.minsec[11:8]),
                 seg_of(cur.minsec[7:4]), seg_of(cur.minsec[3:0])};

endmodule

### test/tb_bcd_clock_with_set_events.sv
// ----------------------------------------------------------------------------
// tb_bcd_clock_with_set_events
// Self-checking bench for the BCD time-of-day clock. Timer, switch, button
// and ignored events go in on the input stream. A scoreboard tracks the
// prescaler, mm:ss and hour, predicts the display for every accepted item and
// checks each output item field by field. A directed opening is followed by a
// fast run of button events across an hour boundary and by randomised phases
// under several register settings. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_bcd_clock_with_set_events;
  import bcdc_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 220;
  localparam int HOLD_AFTER    = 400;       // results seen before the long hold
  localparam int HOLD_CYCLES   = 500;
  localparam int FAST_ITEMS    = 240;
  localparam int REPORT_LIMIT  = 10;

  // Event kind that the block ignores
  localparam logic [1:0] ACT_NONE = 2'd3;

  // One display item as the block presents it
  typedef struct packed {
    logic [4:0]      hour_count;
    logic [15:0]     time_bcd;
    logic [5:0][7:0] seg;       // sec ones, sec tens, min ones, min tens,
                                // hour ones, hour tens (index 0 first)
  } display_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the clock and holds the displays still to come
  // --------------------------------------------------------------------------
  class clock_tracker;
    logic [3:0]  ticks_per_sec;
    logic [3:0]  secs_per_set;
    logic [3:0]  sel_switch;
    logic        button_en;
    logic [3:0]  prescale;
    logic [15:0] minsec;
    logic [4:0]  hour;
    display_t    expected_q[$];
    int          mismatches;
    int          received;

    function new();
      ticks_per_sec = TPS_RESET;
      secs_per_set  = SPS_RESET;
      sel_switch    = SEL_RESET;
      button_en     = 1'b1;
      prescale      = 4'd0;
      minsec        = MINSEC_RESET;
      hour          = 5'd0;
      mismatches    = 0;
      received      = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [3:0] val);
      case (idx)
        CFG_TICKS_PER_SEC: ticks_per_sec = val;
        CFG_SECS_PER_SET:  secs_per_set  = val;
        CFG_SEL_SWITCH:    sel_switch    = val;
        CFG_BUTTON_EN:     button_en     = val[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] seg_pattern(logic [3:0] d);
      case (d)
        4'd0:    return 8'hC0;
        4'd1:    return 8'hF9;
        4'd2:    return 8'hA4;
        4'd3:    return 8'hB0;
        4'd4:    return 8'h99;
        4'd5:    return 8'h92;
        4'd6:    return 8'h82;
        4'd7:    return 8'hF8;
        4'd8:    return 8'h80;
        4'd9:    return 8'h90;
        default: return SEG_BLANK;
      endcase
    endfunction

    // Ripple one second through ss and mm; a full wrap carries into the hour
    function void tick_second();
      int d;
      int i;
      bit carry;
      carry = 1'b1;
      for (i = 0; i < 4; i++) begin
        if (carry) begin
          d = minsec[4*i +: 4] + 1;
          if (d >= ((i % 2 == 0) ? 10 : 6)) d = 0;
          else carry = 1'b0;
          minsec[4*i +: 4] = d[3:0];
        end
      end
      if (carry) hour = (hour == HOUR_LAST) ? 5'd0 : hour + 5'd1;
    endfunction

    function void add_seconds(logic [3:0] n);
      repeat (n) tick_second();
    endfunction

    // Apply one accepted item and queue the display it leads to
    function void note_event(logic [1:0] act, logic pend, logic [9:0] edg);
      display_t d;
      case (act)
        ACT_TIMER: begin
          if (pend) begin
            prescale = prescale + 4'd1;
            if (prescale == ticks_per_sec) begin
              prescale = 4'd0;
              tick_second();
            end
          end
        end
        ACT_SWITCH: begin
          // switch indexes of ten and up match no edge
          if (sel_switch < 4'd10) begin
            if (edg[sel_switch]) add_seconds(secs_per_set);
          end
        end
        ACT_BUTTON: begin
          if (button_en && edg[0]) add_seconds(secs_per_set);
        end
        default: ;
      endcase
      d.seg[0]     = seg_pattern(minsec[3:0]);
      d.seg[1]     = seg_pattern(minsec[7:4]);
      d.seg[2]     = seg_pattern(minsec[11:8]);
      d.seg[3]     = seg_pattern(minsec[15:12]);
      d.seg[4]     = seg_pattern(4'(hour % 5'd10));
      d.seg[5]     = seg_pattern(4'(hour / 5'd10));
      d.time_bcd   = minsec;
      d.hour_count = hour;
      expected_q.push_back(d);
    endfunction

    function void compare_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d: %s expected %h got %h", received, what, want, got);
      end
    endfunction

    // Check one output item against the oldest prediction
    function void check_display(logic [71:0] word);
      display_t want;
      int i;
      received++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d arrived with nothing predicted: %h", received, word);
        return;
      end
      want = expected_q.pop_front();
      for (i = 0; i < 6; i++)
        compare_field($sformatf("segment digit %0d", i), 16'(want.seg[i]),
                      16'(word[8*i +: 8]));
      compare_field("time_bcd", want.time_bcd, word[63:48]);
      compare_field("hour_count", 16'(want.hour_count), 16'(word[68:64]));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block and its stimulus
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;   // [0] timer_pending, [10:1] edges, rest zero
  logic [1:0]  in_tuser   = '0;   // [1:0] action
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [3:0]  cfg_data   = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [71:0] out_tdata;         // six segment bytes, [63:48] time, [68:64] hour
  logic        cfg_ready;

  clock_tracker tracker;
  int           calm_items = 0;

  bcd_clock_with_set_events u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Check every output item at the edge that takes it
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_display(out_tdata);
  end

  // Idle cycles before the next item: mostly none or short, a few long,
  // now and then a stretch with no gaps at all
  function automatic int pick_gap();
    int r;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    if (r < 98) return $urandom_range(20, 60);
    calm_items = $urandom_range(30, 100);
    return 0;
  endfunction

  // Offer one item after the given gap and hold it until taken
  task automatic push_event(input logic [1:0] act, input logic pend,
                            input logic [9:0] edg, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {5'b0, edg, pend};
    do @(posedge clk); while (!in_tready);
    tracker.note_event(act, pend, edg);
  endtask

  task automatic send_random_event();
    int r;
    logic [1:0] act;
    r = $urandom_range(0, 99);
    if (r < 3) act = ACT_NONE;
    else if (r < 40) act = ACT_TIMER;
    else if (r < 70) act = ACT_SWITCH;
    else act = ACT_BUTTON;
    push_event(act, $urandom_range(0, 9) != 0, 10'($urandom), pick_gap());
  endtask

  // Drop valid, wait for every prediction to be met, then let the block idle
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [3:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [3:0] tps, input logic [3:0] sps,
                                input logic [3:0] sel, input logic ben);
    write_register(CFG_TICKS_PER_SEC, tps);
    write_register(CFG_SECS_PER_SET, sps);
    write_register(CFG_SEL_SWITCH, sel);
    write_register(CFG_BUTTON_EN, {3'b0, ben});
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off once the
  // stream is busy so that the block backs up into its input
  initial begin
    int  r;
    int  stall_left;
    int  calm_left;
    int  hold_left;
    bit  held;
    stall_left = 0;
    calm_left  = 0;
    hold_left  = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && tracker != null && tracker.received >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        out_tready <= 1'b1;
        calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_tready <= 1'b1;
        end else if (r < 93) begin
          out_tready <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else if (r < 97) begin
          out_tready <= 1'b0;
          stall_left = $urandom_range(4, 19);
        end else if (r < 98) begin
          out_tready <= 1'b0;
          stall_left = $urandom_range(20, 59);
        end else begin
          out_tready <= 1'b1;
          calm_left = $urandom_range(50, 200);
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Main sequence
  initial begin
    int ph;
    int guard;
    tracker = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: button from 59:57 rolls the minute and the hour
    push_event(ACT_BUTTON, 1'b0, 10'h001, pick_gap());
    push_event(ACT_BUTTON, 1'b1, 10'h3FE, pick_gap());
    push_event(ACT_SWITCH, 1'b0, 10'h002, pick_gap());
    push_event(ACT_SWITCH, 1'b1, 10'h3FD, pick_gap());
    push_event(ACT_SWITCH, 1'b0, 10'h3FF, pick_gap());
    push_event(ACT_NONE, 1'b1, 10'h3FF, pick_gap());
    push_event(ACT_TIMER, 1'b0, 10'h3FF, pick_gap());
    repeat (10) push_event(ACT_TIMER, 1'b1, 10'h000, pick_gap());

    // Fastest prescaler, largest decimal step, top switch, button off
    settle();
    apply_settings(4'd1, 4'd9, 4'd9, 1'b0);
    push_event(ACT_TIMER, 1'b1, 10'h000, pick_gap());
    push_event(ACT_SWITCH, 1'b0, 10'h200, pick_gap());
    push_event(ACT_BUTTON, 1'b0, 10'h3FF, pick_gap());

    // Zero step and a switch index beyond the edge field
    settle();
    apply_settings(4'd1, 4'd0, 4'd12, 1'b1);
    push_event(ACT_SWITCH, 1'b1, 10'h3FF, pick_gap());
    push_event(ACT_BUTTON, 1'b1, 10'h001, pick_gap());

    // Run the clock a full hour ahead in big steps
    settle();
    apply_settings(4'($urandom), 4'd15, 4'($urandom), 1'b1);
    for (guard = 0; guard < FAST_ITEMS; guard++)
      push_event(ACT_BUTTON, 1'($urandom), 10'($urandom) | 10'h001, pick_gap());

    // Random phases, extremes first
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph)
        0:       apply_settings(4'd1, 4'd1, 4'd0, 1'b1);
        1:       apply_settings(4'd15, 4'd9, 4'd9, 1'b0);
        2:       apply_settings(4'd0, 4'd15, 4'd15, 1'b1);
        3:       apply_settings(4'd2, 4'd0, 4'd10, 1'b1);
        default: apply_settings(4'($urandom), 4'($urandom), 4'($urandom),
                                1'($urandom));
      endcase
      repeat (PHASE_ITEMS) send_random_event();
    end

    settle();
    if (tracker.expected_q.size() != 0)
      $display("%0d predicted results never arrived", tracker.expected_q.size());
    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/bcdc_pkg.sv
rtl/core/bcdc_sec_unit.sv
rtl/core/bcdc_seg_enc.sv
rtl/core/bcd_clock_with_set_events.sv
test/tb_bcd_clock_with_set_events.sv
